### design/rrg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrg_pkg: shared types for the fraction reduction block
// Holds the status bundle that the shared divider reports to its sequencer.
// ----------------------------------------------------------------------------
package rrg_pkg;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage
`default_nettype wire

### design/rrg_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrg_divider: iterative unsigned restoring divider
// Produces one quotient bit per cycle and gives quotient and remainder
// together with a one-cycle done pulse after WIDTH iterations.
// ----------------------------------------------------------------------------
module rrg_divider #(
	parameter int WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire logic [WIDTH-1:0]    dividend,
	input  wire logic [WIDTH-1:0]    divisor,
	output logic [WIDTH-1:0]         quotient,
	output logic [WIDTH-1:0]         remainder,
	output rrg_pkg::div_status_t     status
);
	import rrg_pkg::*;

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] div_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !run_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quotient    = quo_q;
	assign remainder   = rem_q;
	assign status.busy = run_q;
	assign status.done = done_q;

endmodule
`default_nettype wire

### design/rational_reduce_gcd_top.sv
`default_nettype none
// A zero denominator gives its word in the cycle after start is taken.
// Otherwise the word follows the Euclid remainder steps on the shared divider and
// then the divisions of numerator and denominator by the greatest common divisor.
// No new fraction is taken while busy; start is taken again in the result cycle.
// A zero denominator never raises busy, so such words can follow every cycle.
// Reset clears the sequencer and the strobe; the receiver cannot stall results.
// ----------------------------------------------------------------------------
// rational_reduce_gcd_top: signed fraction reduction to lowest terms
// Finds the greatest common divisor of the magnitudes with Euclid's remainder
// loop on a shared divider, divides both by it and puts the sign on the
// numerator. Flags divide by zero and results that do not fit.
// ----------------------------------------------------------------------------
module rational_reduce_gcd_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] numerator,
	input  wire logic signed [VALUE_WIDTH-1:0] denominator,
	output logic                               done,
	output logic signed [VALUE_WIDTH-1:0]      reduced_numerator,
	output logic [VALUE_WIDTH-2:0]             reduced_denominator,
	output logic                               divide_by_zero,
	output logic                               overflow
);
	import rrg_pkg::*;

	localparam int W = VALUE_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EUCL = 2'd1;
	localparam logic [1:0] ST_DIVN = 2'd2;
	localparam logic [1:0] ST_DIVD = 2'd3;

	logic [1:0]   state_q;
	logic         go_q;
	logic         done_q;
	logic [W-1:0] p_q;
	logic [W-1:0] q_q;
	logic [W-1:0] nm_q;
	logic [W-1:0] dm_q;
	logic [W-1:0] qn_q;
	logic         neg_q;
	logic [W-1:0] res_num_q;
	logic [W-2:0] res_den_q;
	logic         dbz_q;
	logic         ovf_q;

	logic [W-1:0] nm_in;
	logic [W-1:0] dm_in;
	logic [W-1:0] div_a;
	logic [W-1:0] div_b;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	div_status_t  div_sts;
	logic         accept;
	logic         rneg;
	logic         ovf;
	logic [W-1:0] qn_neg;

	assign accept = start && !busy;
	assign nm_in  = numerator[W-1] ? (~numerator + W'(1)) : numerator;
	assign dm_in  = denominator[W-1] ? (~denominator + W'(1)) : denominator;

	always_comb begin
		case (state_q)
			ST_DIVN: begin
				div_a = nm_q;
				div_b = p_q;
			end
			ST_DIVD: begin
				div_a = dm_q;
				div_b = p_q;
			end
			default: begin
				div_a = p_q;
				div_b = q_q;
			end
		endcase
	end

	rrg_divider #(
		.WIDTH(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_quo),
		.remainder(div_rem),
		.status   (div_sts)
	);

	// The final quotient of the denominator is on div_quo in the cycle the divider raises done.
	assign rneg   = neg_q && (qn_q != '0);
	assign ovf    = div_quo[W-1] || (!rneg && qn_q[W-1]);
	assign qn_neg = ~qn_q + W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (dm_in == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_EUCL;
							go_q    <= 1'b1;
						end
					end
				end
				ST_EUCL: begin
					if (div_sts.done) begin
						go_q <= 1'b1;
						if (div_rem == '0) begin
							state_q <= ST_DIVN;
						end
					end
				end
				ST_DIVN: begin
					if (div_sts.done) begin
						state_q <= ST_DIVD;
						go_q    <= 1'b1;
					end
				end
				ST_DIVD: begin
					if (div_sts.done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (accept) begin
				p_q       <= nm_in;
				q_q       <= dm_in;
				nm_q      <= nm_in;
				dm_q      <= dm_in;
				neg_q     <= numerator[W-1] ^ denominator[W-1];
				res_num_q <= '0;
				res_den_q <= '0;
				dbz_q     <= (dm_in == '0);
				ovf_q     <= 1'b0;
			end
		end else if (state_q == ST_EUCL) begin
			if (div_sts.done) begin
				p_q <= q_q;
				q_q <= div_rem;
			end
		end else if (state_q == ST_DIVN) begin
			if (div_sts.done) begin
				qn_q <= div_quo;
			end
		end else begin
			if (div_sts.done) begin
				dbz_q     <= 1'b0;
				ovf_q     <= ovf;
				res_num_q <= ovf ? '0 : (rneg ? qn_neg : qn_q);
				res_den_q <= ovf ? '0 : div_quo[W-2:0];
			end
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign done                = done_q;
	assign reduced_numerator   = res_num_q;
	assign reduced_denominator = res_den_q;
	assign divide_by_zero      = dbz_q;
	assign overflow            = ovf_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_sts.busy)
		else $error("Divider runs while the sequencer is idle.");

	a_go_starts: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> div_sts.busy)
		else $error("Divider did not start after a launch.");

	a_dbz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (reduced_denominator == '0 && !overflow))
		else $error("Divide-by-zero word carries a value or overflow.");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !divide_by_zero && !overflow) |-> (reduced_denominator != '0))
		else $error("Valid word has a zero denominator.");

	a_done_from_divd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !divide_by_zero) |-> ($past(state_q) == ST_DIVD))
		else $error("Result strobe without a finished reduction.");

endmodule
`default_nettype wire
